// ===== rtl/atp_pkg.sv =====
// Shared widths, types and the arctangent table for the tilt-to-position block.
package atp_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int CENTER_W    = 12;
  localparam int ROLL_W      = 16;
  localparam int PITCH_W     = 15;
  localparam int BUBBLE_W    = 14;
  localparam int CFG_INDEX_W = 2;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y = 2'd1;

  // vector components carry 8 fraction bits
  localparam int WORK_FRAC = 8;

  // y^2 + z^2 reaches 2^31; radicand is that sum scaled by 2^16
  localparam int SQ_W   = 32;
  localparam int RAD_W  = SQ_W + 2 * WORK_FRAC;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  // CORDIC datapath: vector grows by the CORDIC gain, angle in deg * 2^16
  localparam int LANES    = 2;
  localparam int VEC_W    = 27;
  localparam int ACC_W    = 26;
  localparam int ATAN_LEN = 24;
  localparam int ATAN_W   = 22;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [VEC_W-1:0]    vec_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  localparam acc_t DEG90 = acc_t'(90 * 65536);

  // atan(2^-i) in degrees * 2^16, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_q16(input int i);
    logic [ATAN_W-1:0] v;
    case (i)
      0:       v = 22'd2949120;
      1:       v = 22'd1740967;
      2:       v = 22'd919879;
      3:       v = 22'd466945;
      4:       v = 22'd234379;
      5:       v = 22'd117304;
      6:       v = 22'd58666;
      7:       v = 22'd29335;
      8:       v = 22'd14668;
      9:       v = 22'd7334;
      10:      v = 22'd3667;
      11:      v = 22'd1833;
      12:      v = 22'd917;
      13:      v = 22'd458;
      14:      v = 22'd229;
      15:      v = 22'd115;
      16:      v = 22'd57;
      17:      v = 22'd29;
      18:      v = 22'd14;
      19:      v = 22'd7;
      20:      v = 22'd4;
      21:      v = 22'd2;
      22:      v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/atp_sqrt.sv =====
// Pipelined floor square root of (sum << 16), one root bit per stage.
module atp_sqrt #(
  parameter int SIDE_W = 48
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [atp_pkg::SQ_W-1:0]    sq,
  input  logic [SIDE_W-1:0]           side_in,
  output logic                        out_valid,
  output logic [atp_pkg::ROOT_W-1:0]  root,
  output logic [SIDE_W-1:0]           side_out
);

  localparam int STEPS = atp_pkg::ROOT_W;
  localparam int RAD_W = atp_pkg::RAD_W;
  localparam int REM_W = atp_pkg::REM_W;
  localparam int RT_W  = atp_pkg::ROOT_W;

  logic [STEPS:1]   valid_q;
  logic [RAD_W-1:0] rad_q  [1:STEPS];
  logic [REM_W-1:0] rem_q  [1:STEPS];
  logic [RT_W-1:0]  rt_q   [1:STEPS];
  logic [SIDE_W-1:0] side_q [1:STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic             p_valid;
    logic [RAD_W-1:0] p_rad;
    logic [REM_W-1:0] p_rem;
    logic [RT_W-1:0]  p_rt;
    logic [SIDE_W-1:0] p_side;
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    logic             fit;

    if (k == 0) begin : g_src
      assign p_valid = in_valid;
      assign p_rad   = {sq, {(2 * atp_pkg::WORK_FRAC){1'b0}}};
      assign p_rem   = '0;
      assign p_rt    = '0;
      assign p_side  = side_in;
    end else begin : g_src
      assign p_valid = valid_q[k];
      assign p_rad   = rad_q[k];
      assign p_rem   = rem_q[k];
      assign p_rt    = rt_q[k];
      assign p_side  = side_q[k];
    end

    // bring down two radicand bits, try root*4+1
    always_comb begin
      cur   = {p_rem[REM_W-3:0], p_rad[RAD_W-1 -: 2]};
      trial = {p_rt, 2'b01};
      fit   = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k+1] <= 1'b0;
      end else if (en) begin
        valid_q[k+1] <= p_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k+1]  <= {p_rad[RAD_W-3:0], 2'b00};
        rem_q[k+1]  <= fit ? (cur - trial) : cur;
        rt_q[k+1]   <= {p_rt[RT_W-2:0], fit};
        side_q[k+1] <= p_side;
      end
    end
  end

  assign out_valid = valid_q[STEPS];
  assign root      = rt_q[STEPS];
  assign side_out  = side_q[STEPS];

endmodule

// ===== rtl/atp_cordic.sv =====
// Two-lane pipelined CORDIC vectoring: atan2(b, a) in degrees * 2^16.
module atp_cordic #(
  parameter int STAGES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  atp_pkg::vec_t               a_in  [atp_pkg::LANES],
  input  atp_pkg::vec_t               b_in  [atp_pkg::LANES],
  output logic                        out_valid,
  output atp_pkg::acc_t               angle [atp_pkg::LANES],
  output logic [atp_pkg::LANES-1:0]   zero
);

  localparam int NS    = (STAGES < atp_pkg::ATAN_LEN) ? STAGES : atp_pkg::ATAN_LEN;
  localparam int LANES = atp_pkg::LANES;
  localparam int MSB   = atp_pkg::VEC_W - 1;

  logic [NS:0]          valid_q;
  atp_pkg::vec_t        a_q    [LANES][0:NS];
  atp_pkg::vec_t        b_q    [LANES][0:NS];
  atp_pkg::acc_t        acc_q  [LANES][0:NS];
  logic                 zero_q [LANES][0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NS-1:0], in_valid};
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    atp_pkg::vec_t pa;
    atp_pkg::vec_t pb;
    atp_pkg::acc_t pacc;

    // left half plane: turn by +-90 degrees first
    always_comb begin
      pa   = a_in[l];
      pb   = b_in[l];
      pacc = '0;
      if (a_in[l][MSB]) begin
        if (!b_in[l][MSB]) begin
          pa   = b_in[l];
          pb   = -a_in[l];
          pacc = atp_pkg::DEG90;
        end else begin
          pa   = -b_in[l];
          pb   = a_in[l];
          pacc = -atp_pkg::DEG90;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_q[l][0]    <= pa;
        b_q[l][0]    <= pb;
        acc_q[l][0]  <= pacc;
        zero_q[l][0] <= (a_in[l] == '0) && (b_in[l] == '0);
      end
    end

    for (genvar i = 0; i < NS; i++) begin : g_iter
      localparam atp_pkg::acc_t STEP_ANGLE = atp_pkg::acc_t'(atp_pkg::atan_q16(i));
      atp_pkg::vec_t da;
      atp_pkg::vec_t db;

      assign da = b_q[l][i] >>> i;
      assign db = a_q[l][i] >>> i;

      always_ff @(posedge clk) begin
        if (en) begin
          if (!b_q[l][i][MSB]) begin
            a_q[l][i+1]   <= a_q[l][i] + da;
            b_q[l][i+1]   <= b_q[l][i] - db;
            acc_q[l][i+1] <= acc_q[l][i] + STEP_ANGLE;
          end else begin
            a_q[l][i+1]   <= a_q[l][i] - da;
            b_q[l][i+1]   <= b_q[l][i] + db;
            acc_q[l][i+1] <= acc_q[l][i] - STEP_ANGLE;
          end
          zero_q[l][i+1] <= zero_q[l][i];
        end
      end
    end

    assign angle[l] = acc_q[l][NS];
    assign zero[l]  = zero_q[l][NS];
  end

  assign out_valid = valid_q[NS];

endmodule

// ===== rtl/accel_tilt_to_position_top.sv =====
// Top level: accelerometer sample to roll, pitch and bubble position.
//
// One request carries a signed x, y, z sample; one result comes back with
// roll = atan2(y, z) and pitch = atan2(-x, sqrt(y^2 + z^2)), both in
// degrees * 128, and the bubble position center_x + whole-degree roll,
// center_y - whole-degree pitch (whole degrees truncated toward zero).
// The pipeline takes one request per cycle; its depth is set by the 24-stage
// square root (one root bit per stage), the CORDIC (one iteration per stage)
// and the capture, squaring, rounding and output registers. The whole
// pipeline advances whenever the output register is empty or being taken, so
// in_ready drops only while a finished result is held. center_x and center_y
// are written through cfg_write/cfg_index/cfg_data and are read at the last
// stage; write them only while no request is in flight.
module accel_tilt_to_position_top #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration
  input  logic                                   cfg_write,
  input  logic [atp_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [atp_pkg::CENTER_W-1:0]           cfg_data,
  // request channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [atp_pkg::SAMPLE_W-1:0]    accel_x,
  input  logic signed [atp_pkg::SAMPLE_W-1:0]    accel_y,
  input  logic signed [atp_pkg::SAMPLE_W-1:0]    accel_z,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [atp_pkg::ROLL_W-1:0]      roll_angle,
  output logic signed [atp_pkg::PITCH_W-1:0]     pitch_angle,
  output logic signed [atp_pkg::BUBBLE_W-1:0]    bubble_x,
  output logic signed [atp_pkg::BUBBLE_W-1:0]    bubble_y
);

  localparam int SW      = atp_pkg::SAMPLE_W;
  localparam int VW      = atp_pkg::VEC_W;
  localparam int AW      = atp_pkg::ACC_W;
  localparam int RW      = atp_pkg::ROLL_W;
  localparam int BW      = atp_pkg::BUBBLE_W;
  localparam int SIDE_W  = 3 * SW;
  localparam int Q7_SHIFT = 9;            // deg*2^16 -> deg*2^7
  localparam int Q_W     = AW - Q7_SHIFT + 1;
  localparam logic [Q_W-1:0] ROLL_LIMIT  = Q_W'(23040);
  localparam logic [Q_W-1:0] PITCH_LIMIT = Q_W'(11520);
  localparam logic [AW-1:0]  Q7_HALF     = AW'(256);
  localparam int FRAC7   = 7;

  // round to nearest (ties away from zero), saturate to +-limit
  function automatic logic signed [RW-1:0] to_q7(input atp_pkg::acc_t v,
                                                 input logic [Q_W-1:0] limit);
    logic [AW-1:0]  mag;
    logic [AW-1:0]  sum;
    logic [Q_W-1:0] r;
    logic [RW-1:0]  rs;
    mag = v[AW-1] ? AW'(-v) : AW'(v);
    sum = mag + Q7_HALF;
    r   = Q_W'(sum >> Q7_SHIFT);
    if (r > limit) r = limit;
    rs  = r[RW-1:0];
    return v[AW-1] ? -rs : rs;
  endfunction

  // whole degrees, truncated toward zero
  function automatic logic signed [BW-1:0] whole_deg(input logic signed [RW-1:0] q7);
    logic [RW-1:0] mag;
    logic [BW-1:0] w;
    mag = q7[RW-1] ? -q7 : q7;
    w   = BW'(mag >> FRAC7);
    return q7[RW-1] ? -w : w;
  endfunction

  // global advance: the output register is free or being drained
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // configuration registers
  logic [atp_pkg::CENTER_W-1:0] center_x;
  logic [atp_pkg::CENTER_W-1:0] center_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= atp_pkg::CENTER_W'(160);
      center_y <= atp_pkg::CENTER_W'(120);
    end else if (cfg_write) begin
      if (cfg_index == atp_pkg::REG_CENTER_X) center_x <= cfg_data;
      if (cfg_index == atp_pkg::REG_CENTER_Y) center_y <= cfg_data;
    end
  end

  // stage 0: request capture
  logic             v0;
  atp_pkg::sample_t x0, y0, z0;

  // stage 1: squares
  logic                 v1;
  atp_pkg::sample_t     x1, y1, z1;
  logic signed [31:0]   yy1, zz1;

  // stage 2: sum of squares
  logic                      v2;
  atp_pkg::sample_t          x2, y2, z2;
  logic [atp_pkg::SQ_W-1:0]  sq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0  <= accel_x;
      y0  <= accel_y;
      z0  <= accel_z;
      yy1 <= y0 * y0;
      zz1 <= z0 * z0;
      x1  <= x0;
      y1  <= y0;
      z1  <= z0;
      sq2 <= atp_pkg::SQ_W'($unsigned(yy1)) + atp_pkg::SQ_W'($unsigned(zz1));
      x2  <= x1;
      y2  <= y1;
      z2  <= z1;
    end
  end

  // square root stages, sample carried alongside
  logic                        v3;
  logic [atp_pkg::ROOT_W-1:0]  mag3;
  logic [SIDE_W-1:0]           side3;
  atp_pkg::sample_t            x3, y3, z3;

  atp_sqrt #(
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .sq        (sq2),
    .side_in   ({x2, y2, z2}),
    .out_valid (v3),
    .root      (mag3),
    .side_out  (side3)
  );

  assign x3 = side3[3*SW-1 -: SW];
  assign y3 = side3[2*SW-1 -: SW];
  assign z3 = side3[SW-1:0];

  // CORDIC inputs: lane 0 roll (z, y), lane 1 pitch (mag, -x), all Q8
  atp_pkg::vec_t a_in [atp_pkg::LANES];
  atp_pkg::vec_t b_in [atp_pkg::LANES];
  atp_pkg::vec_t x_q8;

  assign x_q8    = {{(VW-SW-atp_pkg::WORK_FRAC){x3[SW-1]}}, x3, {atp_pkg::WORK_FRAC{1'b0}}};
  assign a_in[0] = {{(VW-SW-atp_pkg::WORK_FRAC){z3[SW-1]}}, z3, {atp_pkg::WORK_FRAC{1'b0}}};
  assign b_in[0] = {{(VW-SW-atp_pkg::WORK_FRAC){y3[SW-1]}}, y3, {atp_pkg::WORK_FRAC{1'b0}}};
  assign a_in[1] = {{(VW-atp_pkg::ROOT_W){1'b0}}, mag3};
  assign b_in[1] = -x_q8;

  logic                       v4;
  atp_pkg::acc_t              angle4 [atp_pkg::LANES];
  logic [atp_pkg::LANES-1:0]  zero4;

  atp_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .a_in      (a_in),
    .b_in      (b_in),
    .out_valid (v4),
    .angle     (angle4),
    .zero      (zero4)
  );

  // rounding stage; a zero vector answers 0
  logic                                v5;
  logic signed [RW-1:0]                roll5;
  logic signed [atp_pkg::PITCH_W-1:0]  pitch5;
  logic signed [RW-1:0]                pitch_full;

  assign pitch_full = to_q7(angle4[1], PITCH_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll5  <= zero4[0] ? '0 : to_q7(angle4[0], ROLL_LIMIT);
      pitch5 <= zero4[1] ? '0 : pitch_full[atp_pkg::PITCH_W-1:0];
    end
  end

  // output register: angles and bubble position
  always_ff @(posedge clk) begin
    if (en) begin
      roll_angle  <= roll5;
      pitch_angle <= pitch5;
      bubble_x    <= BW'({1'b0, center_x}) + whole_deg(roll5);
      bubble_y    <= BW'({1'b0, center_y}) - whole_deg(RW'(pitch5));
    end
  end

endmodule

// ===== rtl/atp_checker.sv =====
// Port-level checker for the tilt-to-position block, with its bind.
module atp_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [atp_pkg::ROLL_W-1:0]      roll_angle,
  input logic signed [atp_pkg::PITCH_W-1:0]     pitch_angle,
  input logic signed [atp_pkg::BUBBLE_W-1:0]    bubble_x,
  input logic signed [atp_pkg::BUBBLE_W-1:0]    bubble_y
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(roll_angle) && $stable(pitch_angle) &&
                                $stable(bubble_x) && $stable(bubble_y))
    else $error("result changed while stalled");

  // angles stay inside their saturation limits
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (roll_angle >= -16'sd23040) && (roll_angle <= 16'sd23040) &&
                  (pitch_angle >= -15'sd11520) && (pitch_angle <= 15'sd11520))
    else $error("angle outside range");

  // the pipeline takes requests exactly when the result side is not blocked
  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow result side");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind accel_tilt_to_position_top atp_checker u_atp_checker (.*);
